// ===== sv/bpc_pkg.sv =====
// ============================================================================
// Barometric pressure compensation package
// Shared types, constants and small arithmetic helpers for the compensation
// pipeline.
// ============================================================================
package bpc_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_OVERSAMPLING = 2'd0;
    localparam logic [1:0] REG_CAL_WORD_A   = 2'd1;
    localparam logic [1:0] REG_CAL_WORD_B   = 2'd2;
    localparam logic [1:0] REG_CAL_WORD_C   = 2'd3;

    // Datasheet constants.
    localparam logic [31:0] B6_OFFSET    = 32'd4000;
    localparam logic [31:0] P_COEF_SQ    = 32'd3038;
    localparam logic [31:0] P_COEF_LIN   = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] P_COEF_BIAS  = 32'd3791;
    localparam logic [31:0] B7_SCALE     = 32'd50000;
    localparam logic [31:0] B4_BIAS      = 32'd32768;
    localparam int          DIV_BITS     = 32;

    localparam logic signed [31:0] TEMP_MAX = 32'sd32767;
    localparam logic signed [31:0] TEMP_MIN = -32'sd32768;
    localparam logic signed [31:0] PRES_MAX = 32'sd1048575;

    // Item state carried through the pipeline.
    typedef struct packed {
        logic        fault;
        logic [15:0] ut;
        logic [31:0] up;
        logic [31:0] x1;
        logic [31:0] b5;
        logic [31:0] b6;
        logic [31:0] sq;
        logic [31:0] ma2;
        logic [31:0] ma3;
        logic [31:0] mb2;
        logic [31:0] mb1;
        logic [31:0] b3;
        logic [31:0] x3b;
        logic [31:0] b4;
        logic [31:0] b7;
        logic        big;
        logic [31:0] p;
        logic [31:0] x1p;
        logic [31:0] x2p;
        logic [15:0] temp_out;
        logic [19:0] pres_out;
    } item_t;

    // State of one restoring divider lane.
    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
        logic [32:0] rem;
        logic [31:0] quo;
        logic        neg;
    } div_t;

    // Arithmetic shift right of a 32-bit word.
    function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
        asr32 = 32'($signed(x) >>> n);
    endfunction

    // Sign extension of a 16-bit coefficient.
    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    // Magnitude of a two's complement word.
    function automatic logic [31:0] mag32(input logic [31:0] x);
        mag32 = x[31] ? (32'd0 - x) : x;
    endfunction

    // One quotient bit of restoring division.
    function automatic div_t div_step(input div_t d, input logic [4:0] bitpos);
        logic [32:0] rem_sh;
        div_t        r;
        r      = d;
        rem_sh = {d.rem[31:0], d.num[bitpos]};
        if (rem_sh >= {1'b0, d.den})
        begin
            r.rem         = rem_sh - {1'b0, d.den};
            r.quo[bitpos] = 1'b1;
        end
        else
        begin
            r.rem         = rem_sh;
            r.quo[bitpos] = 1'b0;
        end
        div_step = r;
    endfunction

endpackage

// ===== sv/barometric_pressure_compensation_top.sv =====
// ============================================================================
// Barometric pressure compensation top level
// Pipelined integer compensation of raw temperature and pressure samples.
// ============================================================================
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------
//  input    | in_valid / in_stall    | raw_temperature, raw_pressure_bytes
//  output   | out_valid / out_stall  | temperature_tenths, pressure_pa, divide_fault
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One sample enters per cycle while in_stall is low. A sample passes 75 register
//  stages (3 + 32 + 5 + 32 + 3); the two 32-stage restoring dividers (one
//  quotient bit per stage) make up most of them.
//  Reset clears all valid bits and the calibration registers to zero.
//  A stalled valid result freezes the whole pipeline and raises in_stall.
//  Configuration writes are always taken (cfg_ready is high).
//
module barometric_pressure_compensation_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] raw_temperature,
    input  logic [23:0] raw_pressure_bytes,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [15:0] temperature_tenths,
    output logic [19:0] pressure_pa,
    output logic        divide_fault,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    // Configuration registers.
    logic [1:0]  oss_reg;
    logic [63:0] cal_a_reg;
    logic [63:0] cal_b_reg;
    logic [31:0] cal_c_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oss_reg   <= 2'd0;
            cal_a_reg <= 64'd0;
            cal_b_reg <= 64'd0;
            cal_c_reg <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bpc_pkg::REG_OVERSAMPLING: oss_reg   <= cfg_data[1:0];
                bpc_pkg::REG_CAL_WORD_A:   cal_a_reg <= cfg_data;
                bpc_pkg::REG_CAL_WORD_B:   cal_b_reg <= cfg_data;
                bpc_pkg::REG_CAL_WORD_C:   cal_c_reg <= cfg_data[31:0];
                default:                   oss_reg   <= oss_reg;
            endcase
        end
    end

    // Coefficient fields.
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1c, b2c, mc, md;
    assign ac1 = bpc_pkg::sx16(cal_a_reg[15:0]);
    assign ac2 = bpc_pkg::sx16(cal_a_reg[31:16]);
    assign ac3 = bpc_pkg::sx16(cal_a_reg[47:32]);
    assign ac4 = {16'd0, cal_a_reg[63:48]};
    assign ac5 = {16'd0, cal_b_reg[15:0]};
    assign ac6 = {16'd0, cal_b_reg[31:16]};
    assign b1c = bpc_pkg::sx16(cal_b_reg[47:32]);
    assign b2c = bpc_pkg::sx16(cal_b_reg[63:48]);
    assign mc  = bpc_pkg::sx16(cal_c_reg[15:0]);
    assign md  = bpc_pkg::sx16(cal_c_reg[31:16]);

    // The whole pipeline moves unless the output holds a stalled result.
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    localparam int NDIV = bpc_pkg::DIV_BITS;

    bpc_pkg::item_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg, s7_reg, s8_reg;
    bpc_pkg::item_t s9_reg, s10_reg, s11_reg;
    bpc_pkg::item_t s1_next, s2_next, s3_next, s4_next, s5_next, s6_next, s7_next;
    bpc_pkg::item_t s8_next, s9_next, s10_next, s11_next;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic v9_reg, v10_reg, v11_reg;
    bpc_pkg::div_t  s3_div_reg, s3_div_next;

    bpc_pkg::item_t d1_item_reg [NDIV];
    bpc_pkg::div_t  d1_div_reg  [NDIV];
    logic           d1_vld_reg  [NDIV];
    bpc_pkg::item_t d2_item_reg [NDIV];
    bpc_pkg::div_t  d2_div_reg  [NDIV];
    logic           d2_vld_reg  [NDIV];
    bpc_pkg::div_t  d2_init;

    // Stage 1: capture the sample and align the raw pressure.
    always_comb
    begin
        s1_next       = '0;
        s1_next.ut    = raw_temperature;
        s1_next.up    = {8'd0, raw_pressure_bytes} >> (4'd8 - {2'd0, oss_reg});
    end

    // Stage 2: first temperature term.
    always_comb
    begin
        s2_next    = s1_reg;
        s2_next.x1 = bpc_pkg::asr32(({16'd0, s1_reg.ut} - ac6) * ac5, 5'd15);
    end

    // Stage 3: set up the temperature division.
    always_comb
    begin
        logic [31:0] den;
        logic [31:0] num;
        den     = s2_reg.x1 + md;
        num     = mc << 11;
        s3_next = s2_reg;
        s3_next.fault   = (den == 32'd0);
        s3_div_next.num = bpc_pkg::mag32(num);
        s3_div_next.den = bpc_pkg::mag32(den);
        s3_div_next.rem = '0;
        s3_div_next.quo = '0;
        s3_div_next.neg = num[31] ^ den[31];
    end

    // Divider pipelines, one quotient bit per stage.
    always_comb
    begin
        d2_init     = '0;
        d2_init.num = s8_reg.b7[31] ? s8_reg.b7 : {s8_reg.b7[30:0], 1'b0};
        d2_init.den = s8_reg.b4;
    end

    for (genvar k = 0; k < NDIV; k++)
    begin : g_div
        localparam logic [4:0] BITPOS = 5'(NDIV - 1 - k);
        bpc_pkg::item_t i1_in, i2_in;
        bpc_pkg::div_t  q1_in, q2_in;
        logic           w1_in, w2_in;

        if (k == 0)
        begin : g_first
            assign i1_in = s3_reg;
            assign q1_in = s3_div_reg;
            assign w1_in = v3_reg;
            assign i2_in = s8_reg;
            assign q2_in = d2_init;
            assign w2_in = v8_reg;
        end
        else
        begin : g_rest
            assign i1_in = d1_item_reg[k-1];
            assign q1_in = d1_div_reg[k-1];
            assign w1_in = d1_vld_reg[k-1];
            assign i2_in = d2_item_reg[k-1];
            assign q2_in = d2_div_reg[k-1];
            assign w2_in = d2_vld_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                d1_vld_reg[k] <= 1'b0;
                d2_vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                d1_vld_reg[k] <= w1_in;
                d2_vld_reg[k] <= w2_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d1_item_reg[k] <= i1_in;
                d1_div_reg[k]  <= bpc_pkg::div_step(q1_in, BITPOS);
                d2_item_reg[k] <= i2_in;
                d2_div_reg[k]  <= bpc_pkg::div_step(q2_in, BITPOS);
            end
        end
    end

    // Stage 4: B5 and B6.
    always_comb
    begin
        logic [31:0] q;
        logic [31:0] b5;
        q  = d1_div_reg[NDIV-1].neg ? (32'd0 - d1_div_reg[NDIV-1].quo)
                                    : d1_div_reg[NDIV-1].quo;
        b5 = d1_item_reg[NDIV-1].x1 + q;
        s4_next    = d1_item_reg[NDIV-1];
        s4_next.b5 = b5;
        s4_next.b6 = b5 - bpc_pkg::B6_OFFSET;
    end

    // Stage 5: products of B6.
    always_comb
    begin
        s5_next     = s4_reg;
        s5_next.sq  = bpc_pkg::asr32(s4_reg.b6 * s4_reg.b6, 5'd12);
        s5_next.ma2 = bpc_pkg::asr32(ac2 * s4_reg.b6, 5'd11);
        s5_next.ma3 = bpc_pkg::asr32(ac3 * s4_reg.b6, 5'd13);
    end

    // Stage 6: products of the squared term.
    always_comb
    begin
        s6_next     = s5_reg;
        s6_next.mb2 = bpc_pkg::asr32(b2c * s5_reg.sq, 5'd11);
        s6_next.mb1 = bpc_pkg::asr32(b1c * s5_reg.sq, 5'd16);
    end

    // Stage 7: B3 and the B4 factor.
    always_comb
    begin
        logic [31:0] x3;
        logic [31:0] v;
        x3 = s6_reg.mb2 + s6_reg.ma2;
        v  = (((ac1 << 2) + x3) << oss_reg) + 32'd2;
        s7_next     = s6_reg;
        s7_next.b3  = v[31] ? (32'd0 - ((32'd0 - v) >> 2)) : (v >> 2);
        s7_next.x3b = bpc_pkg::asr32(s6_reg.ma3 + s6_reg.mb1 + 32'd2, 5'd2);
    end

    // Stage 8: B4 and B7.
    always_comb
    begin
        logic [31:0] b4;
        b4 = (ac4 * (s7_reg.x3b + bpc_pkg::B4_BIAS)) >> 15;
        s8_next       = s7_reg;
        s8_next.b4    = b4;
        s8_next.b7    = (s7_reg.up - s7_reg.b3) * (bpc_pkg::B7_SCALE >> oss_reg);
        s8_next.big   = 1'b0;
        s8_next.fault = s7_reg.fault || (b4 == 32'd0);
    end

    // Stage 9: pressure quotient and its correction products.
    always_comb
    begin
        logic [31:0] p;
        logic [31:0] t8;
        p  = d2_item_reg[NDIV-1].b7[31] ? {d2_div_reg[NDIV-1].quo[30:0], 1'b0}
                                        : d2_div_reg[NDIV-1].quo;
        t8 = bpc_pkg::asr32(p, 5'd8);
        s9_next     = d2_item_reg[NDIV-1];
        s9_next.big = d2_item_reg[NDIV-1].b7[31];
        s9_next.p   = p;
        s9_next.x1p = t8 * t8;
        s9_next.x2p = bpc_pkg::asr32(bpc_pkg::P_COEF_LIN * p, 5'd16);
    end

    // Stage 10: scale the square term.
    always_comb
    begin
        s10_next     = s9_reg;
        s10_next.x1p = bpc_pkg::asr32(s9_reg.x1p * bpc_pkg::P_COEF_SQ, 5'd16);
    end

    // Stage 11: final sums, saturation and fault masking.
    always_comb
    begin
        logic [31:0] p2;
        logic [31:0] t;
        p2 = s10_reg.p + bpc_pkg::asr32(s10_reg.x1p + s10_reg.x2p + bpc_pkg::P_COEF_BIAS,
                                        5'd4);
        t  = bpc_pkg::asr32(s10_reg.b5 + 32'd8, 5'd4);
        s11_next = s10_reg;
        if (s10_reg.fault)
            s11_next.temp_out = 16'd0;
        else if ($signed(t) > bpc_pkg::TEMP_MAX)
            s11_next.temp_out = 16'h7FFF;
        else if ($signed(t) < bpc_pkg::TEMP_MIN)
            s11_next.temp_out = 16'h8000;
        else
            s11_next.temp_out = t[15:0];
        if (s10_reg.fault || p2[31])
            s11_next.pres_out = 20'd0;
        else if ($signed(p2) > bpc_pkg::PRES_MAX)
            s11_next.pres_out = 20'hFFFFF;
        else
            s11_next.pres_out = p2[19:0];
    end

    // Valid bits of the named stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= d1_vld_reg[NDIV-1];
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= d2_vld_reg[NDIV-1];
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
        end
    end

    // Payload of the named stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg     <= s1_next;
            s2_reg     <= s2_next;
            s3_reg     <= s3_next;
            s3_div_reg <= s3_div_next;
            s4_reg     <= s4_next;
            s5_reg     <= s5_next;
            s6_reg     <= s6_next;
            s7_reg     <= s7_next;
            s8_reg     <= s8_next;
            s9_reg     <= s9_next;
            s10_reg    <= s10_next;
            s11_reg    <= s11_next;
        end
    end

    assign out_valid          = v11_reg;
    assign temperature_tenths = $signed(s11_reg.temp_out);
    assign pressure_pa        = s11_reg.pres_out;
    assign divide_fault       = s11_reg.fault;

`ifndef SYNTHESIS
    // A faulted result carries zero fields.
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_fault |-> temperature_tenths == 16'sd0 && pressure_pa == 20'd0)
        else $error("faulted result has nonzero fields");

    // The divider remainder stays below a nonzero divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        d1_vld_reg[NDIV-1] && d1_div_reg[NDIV-1].den != 32'd0
        |-> d1_div_reg[NDIV-1].rem < {1'b0, d1_div_reg[NDIV-1].den})
        else $error("temperature divider remainder out of range");

    // A frozen pipeline keeps stage 10, which feeds the output stage, and its valid bit.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s10_reg) && $stable(v10_reg))
        else $error("pipeline moved during a stall");
`endif

endmodule
